// File: rtl/core/sha256_message_digest_top_defines.svh
// Assertion macros shared by the SHA-256 digest RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SHA256_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SHA_ASSERT(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/sha256_pkg.sv
// Types, constants and bit functions of the SHA-256 digest core.
// No dependencies; used by sha256_sched, sha256_round and the top level.
package sha256_pkg;

  localparam int unsigned FILL_W  = 6;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUNDS  = 64;
  localparam int unsigned RND_W   = 6;
  localparam int unsigned WIN_D   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned HASH_D  = 8;

  localparam logic [FILL_W-1:0] LEN_START      = 6'd56;
  localparam logic [FILL_W-1:0] BLOCK_LAST     = 6'd63;
  localparam logic [RND_W-1:0]  RND_LAST       = 6'd63;
  localparam logic [IDX_W-1:0]  LAST_WORD_IDX  = 3'd7;
  localparam logic [7:0]        PAD_MARK_BYTE  = 8'h80;
  localparam logic [7:0]        PAD_ZERO_BYTE  = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMP,
    ST_FIN,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic             wr;
    logic [FILL_W-1:0] addr;
    logic [7:0]       data;
    logic             step;
    logic             expand;
  } sch_ctrl_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [RND_W-1:0] round;
  } rnd_ctrl_t;

  typedef logic [HASH_D-1:0][WORD_W-1:0] hash_t;

  localparam hash_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x,
                                            input int unsigned n);
    ror = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] small_sig0(input logic [WORD_W-1:0] x);
    small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_sig1(input logic [WORD_W-1:0] x);
    small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
    big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
    big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

// File: rtl/core/sha256_sched.sv
// Message block store and schedule window of the SHA-256 core.
// Depends on sha256_pkg for the control struct and sigma functions.
module sha256_sched (
  input  logic                            clk_i,
  input  sha256_pkg::sch_ctrl_t           ctrl_i,
  output logic [sha256_pkg::WORD_W-1:0]   w_o
);
  import sha256_pkg::*;

  logic [WORD_W-1:0] win_q [WIN_D];
  logic [WORD_W-1:0] w_new;
  logic [3:0]        wr_word;
  logic [4:0]        wr_off;

  assign wr_word = ctrl_i.addr[5:2];
  assign wr_off  = {~ctrl_i.addr[1:0], 3'b000};

  always_comb begin
    if (ctrl_i.expand) begin
      w_new = win_q[0] + small_sig0(win_q[1]) + win_q[9] + small_sig1(win_q[14]);
    end else begin
      w_new = win_q[0];
    end
  end

  assign w_o = w_new;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      win_q[wr_word][wr_off +: 8] <= ctrl_i.data;
    end else if (ctrl_i.step) begin
      for (int i = 0; i < WIN_D - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_D-1] <= w_new;
    end
  end

endmodule

// File: rtl/core/sha256_round.sv
// Working variables and the shared SHA-256 round unit, one round per cycle.
// Depends on sha256_pkg for K constants, sigma functions and types.
module sha256_round (
  input  logic                          clk_i,
  input  sha256_pkg::rnd_ctrl_t         ctrl_i,
  input  sha256_pkg::hash_t             hash_i,
  input  logic [sha256_pkg::WORD_W-1:0] w_i,
  output sha256_pkg::hash_t             work_o
);
  import sha256_pkg::*;

  hash_t             work_q;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] ch;
  logic [WORD_W-1:0] maj;

  always_comb begin
    ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1  = work_q[7] + big_sig1(work_q[4]) + ch + ROUND_K[ctrl_i.round] + w_i;
    t2  = big_sig0(work_q[0]) + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      work_q <= hash_i;
    end else if (ctrl_i.step) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  assign work_o = work_q;

endmodule

// File: rtl/core/sha256_message_digest_top.sv
// SHA-256 digest top level: byte intake, padding sequencer and digest output.
// Depends on sha256_pkg, sha256_sched, sha256_round and the defines header.
// A full 64-byte block is compressed over 64 rounds, then the working words are added into the hash.
// End of message: mark byte, zero bytes and the 64-bit length, one or two compressions, then 8 words.
// Intake is closed while a block is compressed in the shared round unit.
// Reset: asynchronous, active low; hash words to the initial values, fill and length to zero.
`include "sha256_message_digest_top_defines.svh"

module sha256_message_digest_top #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_axis_tlast_o
);
  import sha256_pkg::*;

  st_e                    state_q, state_d;
  st_e                    ret_q, ret_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [RND_W-1:0]       rnd_q, rnd_d;
  logic [IDX_W-1:0]       oidx_q, oidx_d;
  hash_t                  hash_q, hash_d;
  hash_t                  work;
  logic [WORD_W-1:0]      w;
  sch_ctrl_t              sch;
  rnd_ctrl_t              rctl;
  logic [63:0]            len_ext;
  logic                   out_acc;
  logic                   blk_end;

  assign len_ext = 64'(cnt_q);
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign blk_end = (fill_q == BLOCK_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      hash_q  <= HASH_IV;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      hash_q  <= hash_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ret_d           = ret_q;
    fill_d          = fill_q;
    cnt_d           = cnt_q;
    rnd_d           = rnd_q;
    oidx_d          = oidx_q;
    hash_d          = hash_q;
    sch             = '0;
    sch.addr        = fill_q;
    rctl            = '0;
    rctl.round      = rnd_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i) begin
            sch.wr   = 1'b1;
            sch.data = s_axis_tdata_i;
            fill_d   = fill_q + 1'b1;
            cnt_d    = cnt_q + LENGTH_BITS'(8);
          end
          if (s_axis_tuser_i && blk_end) begin
            rctl.load = 1'b1;
            state_d   = ST_COMP;
            ret_d     = s_axis_tlast_i ? ST_PAD_MARK : ST_IDLE;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        sch.wr   = 1'b1;
        sch.data = PAD_MARK_BYTE;
        fill_d   = fill_q + 1'b1;
        if (blk_end) begin
          rctl.load = 1'b1;
          state_d   = ST_COMP;
          ret_d     = ST_PAD_ZERO;
        end else begin
          state_d = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (fill_q == LEN_START) begin
          state_d = ST_PAD_LEN;
        end else begin
          sch.wr   = 1'b1;
          sch.data = PAD_ZERO_BYTE;
          fill_d   = fill_q + 1'b1;
          if (blk_end) begin
            rctl.load = 1'b1;
            state_d   = ST_COMP;
            ret_d     = ST_PAD_ZERO;
          end
        end
      end
      ST_PAD_LEN: begin
        sch.wr   = 1'b1;
        sch.data = len_ext[{~fill_q[2:0], 3'b000} +: 8];
        fill_d   = fill_q + 1'b1;
        if (blk_end) begin
          rctl.load = 1'b1;
          state_d   = ST_COMP;
          ret_d     = ST_OUT;
        end
      end
      ST_COMP: begin
        rctl.step  = 1'b1;
        sch.step   = 1'b1;
        sch.expand = (rnd_q[5:4] != 2'b00);
        rnd_d      = rnd_q + 1'b1;
        if (rnd_q == RND_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < HASH_D; i++) begin
          hash_d[i] = hash_q[i] + work[i];
        end
        state_d = ret_q;
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          oidx_d = oidx_q + 1'b1;
          if (oidx_q == LAST_WORD_IDX) begin
            hash_d  = HASH_IV;
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tdata_o = {5'b00000, oidx_q, hash_q[oidx_q]};
  assign m_axis_tlast_o = (oidx_q == LAST_WORD_IDX);

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sch),
    .w_o    (w)
  );

  sha256_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (rctl),
    .hash_i (hash_q),
    .w_i    (w),
    .work_o (work)
  );

  `SHA_ASSERT(a_no_overlap, clk_i, rst_ni, !(s_axis_tready_o && m_axis_tvalid_o), "intake open while digest is out")
  `SHA_ASSERT_IMP(a_rnd_idle, clk_i, rst_ni, state_q != ST_COMP, rnd_q == '0, "round count off outside compression")
  `SHA_ASSERT_IMP(a_len_pos, clk_i, rst_ni, state_q == ST_PAD_LEN, fill_q[5:3] == 3'b111, "length bytes outside tail of block")
  `SHA_ASSERT_NXT(a_restart, clk_i, rst_ni, out_acc && m_axis_tlast_o, (state_q == ST_IDLE) && (fill_q == '0) && (cnt_q == '0) && (hash_q == HASH_IV), "no restart after digest")

endmodule
